[src/aqf_pkg.sv]
// Package for the attitude quaternion filter.
// Holds the sequencer state, job and operand codes and the job term table.
// No dependencies.
`default_nettype none
package aqf_pkg;

  localparam logic [1:0] REG_TWO_KP = 2'd0;
  localparam logic [1:0] REG_TWO_KI = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_WB, S_SQLD, S_SQRT, S_SQEND,
    S_DIVLD, S_DIV, S_DIVEND, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    J_SSQ, J_V0, J_V1, J_V2, J_E0, J_E1, J_E2, J_KIDT,
    J_I0, J_I1, J_I2, J_P0, J_P1, J_P2, J_H0, J_H1, J_H2,
    J_N0, J_N1, J_N2, J_N3, J_NSSQ
  } job_t;

  typedef enum logic [4:0] {
    SRC_QW, SRC_QX, SRC_QY, SRC_QZ, SRC_AX, SRC_AY, SRC_AZ,
    SRC_V0, SRC_V1, SRC_V2, SRC_E0, SRC_E1, SRC_E2,
    SRC_H0, SRC_H1, SRC_H2, SRC_N0, SRC_N1, SRC_N2, SRC_N3,
    SRC_KIDT, SRC_KP, SRC_KI, SRC_DT, SRC_RC0, SRC_RC1, SRC_RC2
  } src_t;

  // One product term of a job: operands, subtract flag, last term flag.
  typedef struct packed {
    src_t a;
    src_t b;
    logic neg;
    logic last;
  } term_t;

  function automatic term_t mk(src_t a, src_t b, logic neg, logic last);
    term_t t;
    t.a = a;
    t.b = b;
    t.neg = neg;
    t.last = last;
    return t;
  endfunction

  function automatic term_t job_term(job_t j, logic [1:0] k);
    term_t t;
    t = mk(SRC_QW, SRC_QW, 1'b0, 1'b1);
    case (j)
      J_SSQ: begin
        t = (k == 2'd0) ? mk(SRC_AX, SRC_AX, 1'b0, 1'b0) :
            (k == 2'd1) ? mk(SRC_AY, SRC_AY, 1'b0, 1'b0) :
                          mk(SRC_AZ, SRC_AZ, 1'b0, 1'b1);
      end
      J_V0: t = (k == 2'd0) ? mk(SRC_QX, SRC_QZ, 1'b0, 1'b0) : mk(SRC_QW, SRC_QY, 1'b1, 1'b1);
      J_V1: t = (k == 2'd0) ? mk(SRC_QW, SRC_QX, 1'b0, 1'b0) : mk(SRC_QY, SRC_QZ, 1'b0, 1'b1);
      J_V2: t = (k == 2'd0) ? mk(SRC_QW, SRC_QW, 1'b0, 1'b0) : mk(SRC_QZ, SRC_QZ, 1'b0, 1'b1);
      J_E0: t = (k == 2'd0) ? mk(SRC_AY, SRC_V2, 1'b0, 1'b0) : mk(SRC_AZ, SRC_V1, 1'b1, 1'b1);
      J_E1: t = (k == 2'd0) ? mk(SRC_AZ, SRC_V0, 1'b0, 1'b0) : mk(SRC_AX, SRC_V2, 1'b1, 1'b1);
      J_E2: t = (k == 2'd0) ? mk(SRC_AX, SRC_V1, 1'b0, 1'b0) : mk(SRC_AY, SRC_V0, 1'b1, 1'b1);
      J_KIDT: t = mk(SRC_KI, SRC_DT, 1'b0, 1'b1);
      J_I0: t = mk(SRC_E0, SRC_KIDT, 1'b0, 1'b1);
      J_I1: t = mk(SRC_E1, SRC_KIDT, 1'b0, 1'b1);
      J_I2: t = mk(SRC_E2, SRC_KIDT, 1'b0, 1'b1);
      J_P0: t = mk(SRC_E0, SRC_KP, 1'b0, 1'b1);
      J_P1: t = mk(SRC_E1, SRC_KP, 1'b0, 1'b1);
      J_P2: t = mk(SRC_E2, SRC_KP, 1'b0, 1'b1);
      J_H0: t = mk(SRC_RC0, SRC_DT, 1'b0, 1'b1);
      J_H1: t = mk(SRC_RC1, SRC_DT, 1'b0, 1'b1);
      J_H2: t = mk(SRC_RC2, SRC_DT, 1'b0, 1'b1);
      J_N0: begin
        t = (k == 2'd0) ? mk(SRC_QX, SRC_H0, 1'b1, 1'b0) :
            (k == 2'd1) ? mk(SRC_QY, SRC_H1, 1'b1, 1'b0) :
                          mk(SRC_QZ, SRC_H2, 1'b1, 1'b1);
      end
      J_N1: begin
        t = (k == 2'd0) ? mk(SRC_QW, SRC_H0, 1'b0, 1'b0) :
            (k == 2'd1) ? mk(SRC_QY, SRC_H2, 1'b0, 1'b0) :
                          mk(SRC_QZ, SRC_H1, 1'b1, 1'b1);
      end
      J_N2: begin
        t = (k == 2'd0) ? mk(SRC_QW, SRC_H1, 1'b0, 1'b0) :
            (k == 2'd1) ? mk(SRC_QX, SRC_H2, 1'b1, 1'b0) :
                          mk(SRC_QZ, SRC_H0, 1'b0, 1'b1);
      end
      J_N3: begin
        t = (k == 2'd0) ? mk(SRC_QW, SRC_H2, 1'b0, 1'b0) :
            (k == 2'd1) ? mk(SRC_QX, SRC_H1, 1'b0, 1'b0) :
                          mk(SRC_QY, SRC_H0, 1'b1, 1'b1);
      end
      J_NSSQ: begin
        t = (k == 2'd0) ? mk(SRC_N0, SRC_N0, 1'b0, 1'b0) :
            (k == 2'd1) ? mk(SRC_N1, SRC_N1, 1'b0, 1'b0) :
            (k == 2'd2) ? mk(SRC_N2, SRC_N2, 1'b0, 1'b0) :
                          mk(SRC_N3, SRC_N3, 1'b0, 1'b1);
      end
      default: t = mk(SRC_QW, SRC_QW, 1'b0, 1'b1);
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

[src/attitude_quaternion_filter.sv]
// Attitude quaternion filter top level: sequencer, shared multiplier,
// iterative square root and divider. Depends on aqf_pkg.
//
// Channel | Direction | Handshake          | Content
// in_     | slave     | in_tvalid/tready   | one IMU sample request
// out_    | master    | out_tvalid/tready  | updated attitude quaternion
// cfg_    | write     | cfg_we             | two_kp (index 0), two_ki (index 1)
//
// Each item runs the bit-serial divider three times for a nonzero
// accelerometer vector and four times for the quaternion unless its norm
// is zero, each set after its own 32-step square root. Every product goes
// through the one shared multiplier. The result sits in an output register;
// a stalled output only holds the sequencer at its final step. Reset sets
// the identity attitude, clears the integral and loads the register defaults.
`default_nettype none
module attitude_quaternion_filter
  import aqf_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = 30
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // gyro_x[31:0], gyro_y[63:32], gyro_z[95:64], accel_x[111:96],
  // accel_y[127:112], accel_z[143:128], time_step[167:144]
  input  wire logic [167:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // quat_w[31:0], quat_x[63:32], quat_y[95:64], quat_z[127:96]
  output logic [127:0]      out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_addr,
  input  wire logic [23:0]  cfg_wdata
);

  localparam int F = QUAT_FRAC_BITS;
  localparam int DIV_STEPS = 64;
  localparam int SQRT_STEPS = 32;
  localparam int CNT_W = 6;
  localparam logic signed [71:0] HALF = 72'sd1 <<< (F - 1);
  localparam logic signed [33:0] Q_ONE = 34'sd1 <<< F;
  localparam logic signed [71:0] I32_MAX = 72'sd2147483647;
  localparam logic signed [71:0] I32_MIN = -72'sd2147483648;

  typedef logic signed [33:0] op_t;

  state_t state_r, state_nxt;
  job_t   job_r, job_nxt;
  logic [1:0] term_r, term_nxt;

  // Attitude and integral state.
  op_t q_r [4];
  logic signed [31:0] integ_r [3];
  logic [23:0] kp_r, ki_r;

  // Per-item working registers.
  logic signed [39:0] rate_r [3];
  op_t acc_r [3];
  op_t v_r [3];
  op_t e_r [3];
  op_t h_r [3];
  op_t nq_r [4];
  logic [23:0] dt_r;
  logic [31:0] kidt_r;

  // Shared multiplier and accumulator.
  logic signed [67:0] prod_r;
  logic neg_r, last_r;
  logic signed [71:0] sum_r;

  // Square root and divider.
  logic [CNT_W-1:0] cnt_r;
  logic [63:0] sq_v_r;
  logic [33:0] sq_rem_r;
  logic [31:0] sq_root_r;
  logic [63:0] dv_q_r;
  logic [31:0] dv_rem_r;
  logic dv_neg_r;
  logic [1:0] div_idx_r;

  logic out_tvalid_r;
  logic [127:0] out_data_r;

  term_t tm;
  op_t op_a, op_b;
  logic acc_nz;
  logic quat_phase;
  logic out_free;

  function automatic logic signed [31:0] sat32(logic signed [71:0] v);
    if (v > I32_MAX) return 32'sh7fffffff;
    if (v < I32_MIN) return -32'sh80000000;
    return v[31:0];
  endfunction

  function automatic op_t pick(src_t s, op_t q [4], op_t a [3], op_t v [3],
                               op_t e [3], op_t h [3], op_t n [4],
                               logic [31:0] kidt, logic [23:0] kp,
                               logic [23:0] ki, logic [23:0] dt,
                               logic signed [39:0] r [3]);
    op_t o;
    o = '0;
    case (s)
      SRC_QW: o = q[0];
      SRC_QX: o = q[1];
      SRC_QY: o = q[2];
      SRC_QZ: o = q[3];
      SRC_AX: o = a[0];
      SRC_AY: o = a[1];
      SRC_AZ: o = a[2];
      SRC_V0: o = v[0];
      SRC_V1: o = v[1];
      SRC_V2: o = v[2];
      SRC_E0: o = e[0];
      SRC_E1: o = e[1];
      SRC_E2: o = e[2];
      SRC_H0: o = h[0];
      SRC_H1: o = h[1];
      SRC_H2: o = h[2];
      SRC_N0: o = n[0];
      SRC_N1: o = n[1];
      SRC_N2: o = n[2];
      SRC_N3: o = n[3];
      SRC_KIDT: o = {2'b00, kidt};
      SRC_KP: o = {10'b0, kp};
      SRC_KI: o = {10'b0, ki};
      SRC_DT: o = {10'b0, dt};
      SRC_RC0: o = 34'(sat32(72'(r[0])));
      SRC_RC1: o = 34'(sat32(72'(r[1])));
      SRC_RC2: o = 34'(sat32(72'(r[2])));
      default: o = '0;
    endcase
    return o;
  endfunction

  assign tm = job_term(job_r, term_r);
  assign op_a = pick(tm.a, q_r, acc_r, v_r, e_r, h_r, nq_r, kidt_r, kp_r, ki_r, dt_r, rate_r);
  assign op_b = pick(tm.b, q_r, acc_r, v_r, e_r, h_r, nq_r, kidt_r, kp_r, ki_r, dt_r, rate_r);
  assign acc_nz = (in_tdata[143:96] != '0);
  assign quat_phase = (job_r == J_NSSQ);
  assign out_free = !out_tvalid_r || out_tready;

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_data_r;

  // Write-back values, built from floor shifts of the accumulator.
  logic signed [71:0] sh_f, sh_i, sh_h, sh_16, int_sum;
  logic signed [31:0] int_sat;
  op_t h_sat;
  assign sh_f = sum_r >>> F;
  assign sh_i = sum_r >>> (F + 8);
  assign sh_h = sum_r >>> (41 - F);
  assign sh_16 = sum_r >>> 16;
  always_comb begin
    int_sum = 72'sd0;
    case (job_r)
      J_I0: int_sum = 72'(integ_r[0]) + sh_i;
      J_I1: int_sum = 72'(integ_r[1]) + sh_i;
      J_I2: int_sum = 72'(integ_r[2]) + sh_i;
      default: int_sum = 72'sd0;
    endcase
  end
  assign int_sat = sat32(int_sum);
  assign h_sat = (sh_h > HALF) ? 34'(HALF) : (sh_h < -HALF) ? 34'(-HALF) : sh_h[33:0];

  // Square root and divide steps.
  logic [35:0] sq_rs, sq_trial;
  logic [32:0] dv_rs, dv_den;
  logic [63:0] dv_mag;
  logic signed [63:0] dv_num;
  op_t dv_res;
  assign sq_rs = {sq_rem_r, sq_v_r[63:62]};
  assign sq_trial = {2'b00, sq_root_r, 2'b01};
  assign dv_rs = {dv_rem_r, dv_q_r[63]};
  assign dv_den = {1'b0, sq_root_r};
  assign dv_num = quat_phase ? (64'(nq_r[div_idx_r]) <<< F)
                             : (64'(acc_r[div_idx_r[1:0]]) <<< (F + 16));
  assign dv_mag = dv_num[63] ? 64'(-dv_num) : 64'(dv_num);
  assign dv_res = dv_neg_r ? 34'(-$signed(dv_q_r)) : dv_q_r[33:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      job_r <= J_SSQ;
      term_r <= '0;
    end else begin
      state_r <= state_nxt;
      job_r <= job_nxt;
      term_r <= term_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt = job_r;
    term_nxt = term_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_MUL;
          term_nxt = '0;
          job_nxt = acc_nz ? J_SSQ : J_H0;
        end
      end
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        if (last_r) state_nxt = S_WB;
        else begin
          term_nxt = term_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_WB: begin
        term_nxt = '0;
        state_nxt = S_MUL;
        case (job_r)
          J_SSQ: state_nxt = S_SQLD;
          J_V0: job_nxt = J_V1;
          J_V1: job_nxt = J_V2;
          J_V2: job_nxt = J_E0;
          J_E0: job_nxt = J_E1;
          J_E1: job_nxt = J_E2;
          J_E2: job_nxt = (ki_r != '0) ? J_KIDT : J_P0;
          J_KIDT: job_nxt = J_I0;
          J_I0: job_nxt = J_I1;
          J_I1: job_nxt = J_I2;
          J_I2: job_nxt = J_P0;
          J_P0: job_nxt = J_P1;
          J_P1: job_nxt = J_P2;
          J_P2: job_nxt = J_H0;
          J_H0: job_nxt = J_H1;
          J_H1: job_nxt = J_H2;
          J_H2: job_nxt = J_N0;
          J_N0: job_nxt = J_N1;
          J_N1: job_nxt = J_N2;
          J_N2: job_nxt = J_N3;
          J_N3: job_nxt = J_NSSQ;
          J_NSSQ: state_nxt = S_SQLD;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SQLD: state_nxt = S_SQRT;
      S_SQRT: if (cnt_r == CNT_W'(SQRT_STEPS - 1)) state_nxt = S_SQEND;
      S_SQEND: state_nxt = (quat_phase && sq_root_r == '0) ? S_DONE : S_DIVLD;
      S_DIVLD: state_nxt = S_DIV;
      S_DIV: if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_nxt = S_DIVEND;
      S_DIVEND: begin
        if (quat_phase && div_idx_r == 2'd3) state_nxt = S_DONE;
        else if (!quat_phase && div_idx_r == 2'd2) begin
          state_nxt = S_MUL;
          job_nxt = J_V0;
          term_nxt = '0;
        end else state_nxt = S_DIVLD;
      end
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r[0] <= Q_ONE;
      q_r[1] <= '0;
      q_r[2] <= '0;
      q_r[3] <= '0;
      for (int i = 0; i < 3; i++) integ_r[i] <= '0;
      kp_r <= 24'd65536;
      ki_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_addr == REG_TWO_KP) kp_r <= cfg_wdata;
      if (cfg_we && cfg_addr == REG_TWO_KI) ki_r <= cfg_wdata;
      if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            rate_r[0] <= 40'($signed(in_tdata[31:0]));
            rate_r[1] <= 40'($signed(in_tdata[63:32]));
            rate_r[2] <= 40'($signed(in_tdata[95:64]));
            acc_r[0] <= 34'($signed(in_tdata[111:96]));
            acc_r[1] <= 34'($signed(in_tdata[127:112]));
            acc_r[2] <= 34'($signed(in_tdata[143:128]));
            dt_r <= in_tdata[167:144];
            sum_r <= '0;
          end
        end
        S_MUL: begin
          prod_r <= op_a * op_b;
          neg_r <= tm.neg;
          last_r <= tm.last;
        end
        S_ACC: sum_r <= neg_r ? sum_r - 72'(prod_r) : sum_r + 72'(prod_r);
        S_WB: begin
          if (job_r != J_SSQ && job_r != J_NSSQ) sum_r <= '0;
          case (job_r)
            J_V0: v_r[0] <= sh_f[33:0];
            J_V1: v_r[1] <= sh_f[33:0];
            J_V2: v_r[2] <= 34'(sh_f - HALF);
            J_E0: e_r[0] <= sh_f[33:0];
            J_E1: e_r[1] <= sh_f[33:0];
            J_E2: begin
              e_r[2] <= sh_f[33:0];
              if (ki_r == '0) for (int i = 0; i < 3; i++) integ_r[i] <= '0;
            end
            J_KIDT: kidt_r <= sh_16[31:0];
            J_I0: begin
              integ_r[0] <= int_sat;
              rate_r[0] <= rate_r[0] + 40'(int_sat);
            end
            J_I1: begin
              integ_r[1] <= int_sat;
              rate_r[1] <= rate_r[1] + 40'(int_sat);
            end
            J_I2: begin
              integ_r[2] <= int_sat;
              rate_r[2] <= rate_r[2] + 40'(int_sat);
            end
            J_P0: rate_r[0] <= rate_r[0] + sh_f[39:0];
            J_P1: rate_r[1] <= rate_r[1] + sh_f[39:0];
            J_P2: rate_r[2] <= rate_r[2] + sh_f[39:0];
            J_H0: h_r[0] <= h_sat;
            J_H1: h_r[1] <= h_sat;
            J_H2: h_r[2] <= h_sat;
            J_N0: nq_r[0] <= q_r[0] + sh_f[33:0];
            J_N1: nq_r[1] <= q_r[1] + sh_f[33:0];
            J_N2: nq_r[2] <= q_r[2] + sh_f[33:0];
            J_N3: nq_r[3] <= q_r[3] + sh_f[33:0];
            default: ;
          endcase
        end
        S_SQLD: begin
          // The accelerometer norm is taken of the sum of squares times 2^32.
          sq_v_r <= quat_phase ? sum_r[63:0] : {sum_r[31:0], 32'b0};
          sq_rem_r <= '0;
          sq_root_r <= '0;
          cnt_r <= '0;
          sum_r <= '0;
        end
        S_SQRT: begin
          if (sq_rs >= sq_trial) begin
            sq_rem_r <= 34'(sq_rs - sq_trial);
            sq_root_r <= {sq_root_r[30:0], 1'b1};
          end else begin
            sq_rem_r <= sq_rs[33:0];
            sq_root_r <= {sq_root_r[30:0], 1'b0};
          end
          sq_v_r <= {sq_v_r[61:0], 2'b00};
          cnt_r <= cnt_r + 1'b1;
        end
        S_SQEND: div_idx_r <= '0;
        S_DIVLD: begin
          dv_neg_r <= dv_num[63];
          dv_q_r <= dv_mag;
          dv_rem_r <= '0;
          cnt_r <= '0;
        end
        S_DIV: begin
          if (dv_rs >= dv_den) begin
            dv_rem_r <= 32'(dv_rs - dv_den);
            dv_q_r <= {dv_q_r[62:0], 1'b1};
          end else begin
            dv_rem_r <= dv_rs[31:0];
            dv_q_r <= {dv_q_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
        end
        S_DIVEND: begin
          if (quat_phase) nq_r[div_idx_r] <= dv_res;
          else acc_r[div_idx_r] <= dv_res;
          div_idx_r <= div_idx_r + 2'd1;
          sum_r <= '0;
        end
        S_DONE: begin
          if (out_free) begin
            for (int i = 0; i < 4; i++) q_r[i] <= nq_r[i];
            out_data_r <= {nq_r[3][31:0], nq_r[2][31:0], nq_r[1][31:0], nq_r[0][31:0]};
            out_tvalid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // A result appears only from the final sequencer step.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the final step");

  // An accepted request always starts the multiplier sequence.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_MUL))
    else $error("accepted request did not start the sequence");

  // The divider never runs with a zero norm.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (sq_root_r != '0))
    else $error("division by a zero norm");

  // The square root ends within its step count.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> (cnt_r < CNT_W'(SQRT_STEPS)))
    else $error("square root ran past its steps");

endmodule
`default_nettype wire

[tb/tb_attitude_quaternion_filter.sv]
// Self-checking testbench for the attitude quaternion filter.
// Each IMU sample is predicted in fixed point and checked against the block's quaternion.
// Depends on aqf_pkg and attitude_quaternion_filter.
`default_nettype none
module tb_attitude_quaternion_filter;
  import aqf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 30;
  localparam longint Q_ONE = longint'(1) <<< FRAC;
  localparam longint HALF = Q_ONE >>> 1;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int DRAIN_CYCLES = 1500;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // gyro_x, gyro_y, gyro_z (32 bit each), accel_x, accel_y, accel_z (16 bit each),
  // time_step (24 bit), from the lowest bit up.
  logic [167:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // quat_w, quat_x, quat_y, quat_z (32 bit each), from the lowest bit up.
  logic [127:0] out_tdata;
  logic cfg_we;
  logic [1:0] cfg_addr;
  logic [23:0] cfg_wdata;

  attitude_quaternion_filter DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // The predicted filter state and its gain registers.
  longint att_q[4];
  longint err_int[3];
  longint unsigned gain_kp;
  longint unsigned gain_ki;

  logic [127:0] quat_expected[$];
  int errors;
  int requests_sent;
  int quats_checked;
  int zero_accel_sent;
  int cycles;
  int burst_left;
  int stall_mode;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Timeout watchdog on a plain cycle counter.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d quaternions pending", cycles,
               quat_expected.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint unsigned isqrt_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Advances the predicted attitude by one IMU sample and returns the packed quaternion.
  function automatic logic [127:0] advance_attitude(logic [167:0] d);
    longint rate[3], acc[3], v[3], e[3], h[3], nq[4];
    longint w, x, y, z, kidt, r;
    longint unsigned dt, ssq, nrm;
    logic [127:0] packed_q;
    w = att_q[0]; x = att_q[1]; y = att_q[2]; z = att_q[3];
    dt = d[167:144];
    for (int i = 0; i < 3; i++) begin
      rate[i] = longint'($signed(d[32*i +: 32]));
      acc[i] = longint'($signed(d[96 + 16*i +: 16]));
    end
    if (acc[0] != 0 || acc[1] != 0 || acc[2] != 0) begin
      // Normalize the accelerometer vector to unit length in the quaternion format.
      ssq = acc[0]*acc[0] + acc[1]*acc[1] + acc[2]*acc[2];
      nrm = isqrt_floor(ssq << 32);
      for (int i = 0; i < 3; i++) acc[i] = (acc[i] <<< (FRAC + 16)) / longint'(nrm);
      // Half of the gravity direction predicted by the attitude.
      v[0] = (x*z - w*y) >>> FRAC;
      v[1] = (w*x + y*z) >>> FRAC;
      v[2] = ((w*w + z*z) >>> FRAC) - HALF;
      e[0] = (acc[1]*v[2] - acc[2]*v[1]) >>> FRAC;
      e[1] = (acc[2]*v[0] - acc[0]*v[2]) >>> FRAC;
      e[2] = (acc[0]*v[1] - acc[1]*v[0]) >>> FRAC;
      if (gain_ki != 0) begin
        kidt = longint'((gain_ki * dt) >> 16);
        for (int i = 0; i < 3; i++) begin
          err_int[i] = clamp(err_int[i] + ((e[i] * kidt) >>> (FRAC + 8)),
                             -64'sd2147483648, 64'sd2147483647);
          rate[i] += err_int[i];
        end
      end else begin
        for (int i = 0; i < 3; i++) err_int[i] = 0;
      end
      for (int i = 0; i < 3; i++) rate[i] += (e[i] * longint'(gain_kp)) >>> FRAC;
    end
    for (int i = 0; i < 3; i++) begin
      r = clamp(rate[i], -64'sd2147483648, 64'sd2147483647);
      h[i] = clamp((r * longint'(dt)) >>> (41 - FRAC), -HALF, HALF);
    end
    nq[0] = w + ((-x*h[0] - y*h[1] - z*h[2]) >>> FRAC);
    nq[1] = x + ((w*h[0] + y*h[2] - z*h[1]) >>> FRAC);
    nq[2] = y + ((w*h[1] - x*h[2] + z*h[0]) >>> FRAC);
    nq[3] = z + ((w*h[2] + x*h[1] - y*h[0]) >>> FRAC);
    ssq = 0;
    for (int i = 0; i < 4; i++) ssq += longint'(nq[i] * nq[i]);
    nrm = isqrt_floor(ssq);
    if (nrm != 0) begin
      for (int i = 0; i < 4; i++) nq[i] = (nq[i] <<< FRAC) / longint'(nrm);
    end
    for (int i = 0; i < 4; i++) begin
      att_q[i] = nq[i];
      packed_q[32*i +: 32] = nq[i][31:0];
    end
    return packed_q;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what,
             $signed(got), $signed(want));
  endtask

  // Every accepted quaternion is compared with the oldest prediction.
  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (quat_expected.size() == 0) begin
        errors++;
        $display("[%0t] Quaternion arrived with no request outstanding", $realtime);
      end else begin
        want = quat_expected.pop_front();
        quats_checked++;
        if (out_tdata[31:0] !== want[31:0]) report_mismatch("quat_w", out_tdata[31:0], want[31:0]);
        if (out_tdata[63:32] !== want[63:32]) report_mismatch("quat_x", out_tdata[63:32], want[63:32]);
        if (out_tdata[95:64] !== want[95:64]) report_mismatch("quat_y", out_tdata[95:64], want[95:64]);
        if (out_tdata[127:96] !== want[127:96]) report_mismatch("quat_z", out_tdata[127:96], want[127:96]);
      end
    end
  end

  // Receiver backpressure: always ready, coin toss, or long stalls, chosen per test.
  always @(negedge clk) begin
    if (stall_mode == 0) begin
      out_tready <= 1'b1;
    end else if (stall_mode == 1) begin
      out_tready <= $urandom_range(0, 1);
    end else begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else begin
        stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 60) : 0;
        out_tready <= 1'b1;
      end
    end
  end

  // Sends one request; the sender idles between bursts of random length.
  task automatic send_sample(logic [167:0] d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40)) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    quat_expected.push_back(advance_attitude(d));
    requests_sent++;
    if (d[143:96] == '0) zero_accel_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (quat_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write while idle; indexes past the two registers change nothing.
  task automatic write_gain(logic [1:0] idx, logic [23:0] val);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TWO_KP) gain_kp = val;
    else if (idx == REG_TWO_KI) gain_ki = val;
  endtask

  function automatic logic [167:0] pack_sample(int gx, int gy, int gz, shortint ax,
                                               shortint ay, shortint az, logic [23:0] dt);
    return {dt, az, ay, ax, gz, gy, gx};
  endfunction

  // A realistic sample: modest rates, gravity mostly on z with noise, millisecond steps.
  function automatic logic [167:0] plausible_sample();
    int g[3];
    shortint a[3];
    for (int i = 0; i < 3; i++) g[i] = int'($urandom_range(0, 1 << 20)) - (1 << 19);
    a[0] = shortint'(int'($urandom_range(0, 8000)) - 4000);
    a[1] = shortint'(int'($urandom_range(0, 8000)) - 4000);
    a[2] = shortint'(int'($urandom_range(8000, 24000)) * ($urandom_range(0, 7) == 0 ? -1 : 1));
    return pack_sample(g[0], g[1], g[2], a[0], a[1], a[2], 24'($urandom_range(1, 40000)));
  endfunction

  function automatic logic [167:0] wild_sample();
    logic [167:0] d;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if ($urandom_range(0, 4) == 0) d[143:96] = '0;
    return d;
  endfunction

  task automatic run_random(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) send_sample(plausible_sample());
      else if (pick < 9) send_sample(wild_sample());
      else send_sample(pack_sample($urandom, $urandom, $urandom, 0, 0, 0, 24'($urandom)));
    end
  endtask

  task automatic test_reset_defaults();
    stall_mode = 0;
    send_sample(pack_sample(0, 0, 0, 0, 0, 0, 24'd0));
    send_sample(pack_sample(0, 0, 0, 0, 0, 16384, 24'd16777));
    send_sample(pack_sample(65536, -65536, 32768, 0, 0, 0, 24'd16777));
    send_sample(pack_sample(0, 0, 0, 16384, 0, 0, 24'd16777));
  endtask

  task automatic test_field_extremes();
    stall_mode = 1;
    // Full-scale rates with the longest step hit the half angle clamp.
    send_sample(pack_sample(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 24'hffffff));
    send_sample(pack_sample(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 24'hffffff));
    send_sample(pack_sample(0, 0, 0, -32768, -32768, -32768, 24'hffffff));
    send_sample(pack_sample(0, 0, 0, 32767, 32767, 32767, 24'd1));
    send_sample(pack_sample(0, 0, 0, 0, -32768, 0, 24'd100000));
    send_sample(pack_sample(1, -1, 0, 1, 0, 0, 24'd0));
    send_sample({168{1'b1}});
    send_sample({84{2'b01}});
    send_sample({84{2'b10}});
  endtask

  task automatic test_gain_extremes();
    // Maximum gains make the corrected rate saturate and the integral grow fast.
    write_gain(REG_TWO_KP, 24'hffffff);
    write_gain(REG_TWO_KI, 24'hffffff);
    stall_mode = 2;
    for (int n = 0; n < 6; n++)
      send_sample(pack_sample(32'h7fffffff, 0, 32'h80000000, 32767, 0, -32768, 24'hffffff));
    send_sample(pack_sample(0, 0, 0, 0, 0, 0, 24'hffffff));
    // Clearing the integral gain clears the integral on the next nonzero accel sample.
    write_gain(REG_TWO_KI, 24'd0);
    send_sample(pack_sample(0, 0, 0, 100, -200, 300, 24'd16777));
    write_gain(REG_TWO_KP, 24'd0);
    send_sample(pack_sample(4096, 0, 0, 0, 5000, 0, 24'd16777));
    // Writes to unused indexes must leave both gains alone.
    write_gain(2'd2, 24'h123456);
    write_gain(2'd3, 24'hfedcba);
    send_sample(pack_sample(0, 4096, 0, 3000, 0, 0, 24'd16777));
  endtask

  task automatic test_random_settings();
    logic [23:0] kp_set[5] = '{24'd65536, 24'd0, 24'hffffff, 24'd32768, 24'd262144};
    logic [23:0] ki_set[5] = '{24'd0, 24'd1, 24'hffffff, 24'd2048, 24'd65536};
    for (int p = 0; p < 5; p++) begin
      write_gain(REG_TWO_KP, kp_set[p]);
      write_gain(REG_TWO_KI, ki_set[p]);
      stall_mode = p % 3;
      run_random(160);
    end
    for (int p = 0; p < 3; p++) begin
      write_gain(REG_TWO_KP, 24'($urandom));
      write_gain(REG_TWO_KI, 24'($urandom));
      stall_mode = $urandom_range(0, 2);
      run_random(100);
    end
  endtask

  initial begin
    errors = 0;
    requests_sent = 0;
    quats_checked = 0;
    zero_accel_sent = 0;
    cycles = 0;
    burst_left = 0;
    stall_mode = 0;
    stall_left = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    att_q = '{Q_ONE, 0, 0, 0};
    err_int = '{0, 0, 0};
    gain_kp = 65536;
    gain_ki = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_field_extremes();
    test_gain_extremes();
    test_random_settings();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d IMU samples (%0d with zero accel) and %0d checked quaternions",
             requests_sent, zero_accel_sent, quats_checked);
    $display("across default, extreme and random gain settings under varied backpressure.");
    if (errors == 0 && quat_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d quaternions missing", errors, quat_expected.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
src/aqf_pkg.sv
src/attitude_quaternion_filter.sv
tb/tb_attitude_quaternion_filter.sv
